>>> rtl/core/sha_pkg.sv
// SHA-256 hasher package: round constants, initial hash values, codes and helpers.
package sha_pkg;

	localparam logic [1:0] MODE_APPEND  = 2'd0;
	localparam logic [1:0] MODE_FINISH  = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FINISHED = 2'd1;
	localparam logic [1:0] ST_CAPACITY = 2'd2;

	localparam logic [7:0] PAD_MARKER = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [60:0] TOTAL_MAX = {61{1'b1}};

	typedef logic [31:0] word_t;
	typedef word_t [7:0] state_t;

	localparam state_t INIT_H = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// sequencer to round engine
	typedef struct packed {
		logic start;
		logic load_word;
		word_t word;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

endpackage

>>> rtl/core/sha_round.sv
// SHA-256 round engine: 16-word schedule window and one round per cycle.
module sha_round import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  core_ctl_t ctl,
	input  logic      restart,
	output core_sts_t sts,
	output state_t    hash
);
	word_t [15:0] w_q;
	state_t s_q;
	state_t h_q;
	logic [5:0] rnd_q;
	logic busy_q;
	logic done_q;
	word_t w_new, t1, t2, x, y;

	always_comb begin
		x = w_q[1];
		y = w_q[14];
		w_new = w_q[0] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w_q[9]
			+ (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
		t1 = s_q[7] + (rotr(s_q[4], 6) ^ rotr(s_q[4], 11) ^ rotr(s_q[4], 25))
			+ ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6])) + round_k(rnd_q) + w_q[0];
		t2 = (rotr(s_q[0], 2) ^ rotr(s_q[0], 13) ^ rotr(s_q[0], 22))
			+ ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= INIT_H;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (restart) begin
				h_q <= INIT_H;
			end
			if (ctl.load_word) begin
				w_q <= {ctl.word, w_q[15:1]};
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
				s_q <= h_q;
			end else if (busy_q) begin
				s_q <= {s_q[6:4], s_q[3] + t1, s_q[2:0], t1 + t2};
				w_q <= {w_new, w_q[15:1]};
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + s_q[i];
			end
		end
	end

	assign sts = '{busy: busy_q | done_q, done: done_q};
	assign hash = h_q;
endmodule

>>> rtl/core/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte packing, padding sequencer and result output.
// Append: bytes are taken back to back; every 64th byte adds a compression (one round per cycle).
// Finish: padding bytes at 1 per cycle, one or two compressions, then 8 results.
// Errors give one result. Not ready while a compression, padding or result output runs.
// Reset (arst_n low, asynchronous) loads the initial hash values and clears counts.
module sha256_stream_hasher import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        ready_in,
	input  logic [1:0]  mode,
	input  logic [7:0]  data_byte,
	output logic        valid_out,
	input  logic        ready_out,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic [1:0]  status
);
	typedef enum logic [2:0] {S_IDLE, S_COMP, S_PAD, S_EMIT, S_ERR} fsm_t;
	fsm_t st_q;
	logic [5:0] fill_q;
	logic [60:0] total_q;
	logic fin_q;
	logic pad_q;
	logic len_q;
	logic [1:0] err_q;
	logic [2:0] idx_q;
	logic [23:0] pack_q;
	core_ctl_t ctl;
	core_sts_t sts;
	state_t hash;
	logic restart, acc;
	logic [7:0] pb;
	logic [63:0] bits;

	assign ready_in = (st_q == S_IDLE);
	assign acc = valid_in && ready_in;
	assign restart = acc && mode == MODE_RESTART;
	assign bits = {total_q, 3'b000};

	// length field only in the block that ends the padding
	always_comb begin
		if (fill_q >= LEN_POS && len_q) pb = bits[8*(63 - fill_q) +: 8];
		else pb = 8'h00;
	end

	always_comb begin
		ctl = '0;
		if (acc && mode == MODE_APPEND && !fin_q && total_q != TOTAL_MAX
			&& fill_q[1:0] == 2'd3) begin
			ctl.load_word = 1'b1;
			ctl.word = {pack_q, data_byte};
		end
		if (acc && mode == MODE_FINISH && !fin_q && fill_q[1:0] == 2'd3) begin
			ctl.load_word = 1'b1;
			ctl.word = {pack_q, PAD_MARKER};
		end
		if (st_q == S_PAD && fill_q[1:0] == 2'd3) begin
			ctl.load_word = 1'b1;
			ctl.word = {pack_q, pb};
		end
		if (ctl.load_word && fill_q == 6'd63) ctl.start = 1'b1;
	end

	sha_round u_round (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .restart(restart), .sts(sts), .hash(hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			fill_q <= '0;
			total_q <= '0;
			fin_q <= 1'b0;
			pad_q <= 1'b0;
			len_q <= 1'b0;
			err_q <= ST_OK;
			idx_q <= '0;
			pack_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						case (mode)
							MODE_RESTART: begin
								fill_q <= '0;
								total_q <= '0;
								fin_q <= 1'b0;
							end
							MODE_APPEND: begin
								if (fin_q) begin
									err_q <= ST_FINISHED;
									st_q <= S_ERR;
								end else if (total_q == TOTAL_MAX) begin
									err_q <= ST_CAPACITY;
									st_q <= S_ERR;
								end else begin
									pack_q <= {pack_q[15:0], data_byte};
									fill_q <= fill_q + 6'd1;
									total_q <= total_q + 61'd1;
									if (fill_q == 6'd63) st_q <= S_COMP;
								end
							end
							MODE_FINISH: begin
								if (fin_q) begin
									err_q <= ST_FINISHED;
									st_q <= S_ERR;
								end else begin
									pack_q <= {pack_q[15:0], PAD_MARKER};
									fill_q <= fill_q + 6'd1;
									pad_q <= 1'b1;
									len_q <= (fill_q < LEN_POS);
									st_q <= (fill_q == 6'd63) ? S_COMP : S_PAD;
								end
							end
							default: ;
						endcase
					end
				end
				S_PAD: begin
					pack_q <= {pack_q[15:0], pb};
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) st_q <= S_COMP;
				end
				S_COMP: begin
					if (!sts.busy && !ctl.start) begin
						if (!pad_q) st_q <= S_IDLE;
						else if (len_q) begin
							fin_q <= 1'b1;
							idx_q <= '0;
							st_q <= S_EMIT;
						end else begin
							len_q <= 1'b1;
							st_q <= S_PAD;
						end
					end
				end
				S_EMIT: begin
					if (ready_out) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							pad_q <= 1'b0;
							st_q <= S_IDLE;
						end
					end
				end
				S_ERR: begin
					if (ready_out) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		valid_out = 1'b0;
		digest_word = '0;
		word_index = '0;
		last_word = 1'b0;
		status = ST_OK;
		if (st_q == S_EMIT) begin
			valid_out = 1'b1;
			digest_word = hash[idx_q];
			word_index = idx_q;
			last_word = (idx_q == 3'd7);
		end else if (st_q == S_ERR) begin
			valid_out = 1'b1;
			last_word = 1'b1;
			status = err_q;
		end
	end
endmodule
